/* design/cpu80_pkg.sv */
// Shared types and constants for the 8080 subset execute unit.
// Holds the channel beat structs, opcode codes, register codes and flag bit positions.
// No dependencies.
package cpu80_pkg;

  typedef struct packed {
    logic [7:0] mode;
    logic [7:0] imm_low;
    logic [7:0] imm_high;
  } in_item_t;

  typedef struct packed {
    logic [15:0] next_pc;
    logic        write_strobe;
    logic [15:0] write_address;
    logic [7:0]  write_value;
    logic [7:0]  accumulator_out;
    logic [4:0]  flags_out;
  } out_item_t;

  localparam logic [7:0] OP_STAX_B = 8'h02;
  localparam logic [7:0] OP_STAX_D = 8'h12;
  localparam logic [7:0] OP_CMC    = 8'h3f;

  localparam logic [3:0] LOW_LXI = 4'h1;
  localparam logic [3:0] LOW_INX = 4'h3;

  localparam logic [2:0] LOW3_INR = 3'd4;
  localparam logic [2:0] LOW3_DCR = 3'd5;
  localparam logic [2:0] LOW3_MVI = 3'd6;

  localparam logic [1:0] GROUP_MISC = 2'd0;

  localparam logic [2:0] REG_B = 3'd0;
  localparam logic [2:0] REG_C = 3'd1;
  localparam logic [2:0] REG_D = 3'd2;
  localparam logic [2:0] REG_E = 3'd3;
  localparam logic [2:0] REG_H = 3'd4;
  localparam logic [2:0] REG_L = 3'd5;
  localparam logic [2:0] REG_M = 3'd6;
  localparam logic [2:0] REG_A = 3'd7;

  localparam logic [1:0] PAIR_BC = 2'd0;
  localparam logic [1:0] PAIR_DE = 2'd1;
  localparam logic [1:0] PAIR_HL = 2'd2;
  localparam logic [1:0] PAIR_SP = 2'd3;

  localparam int FLAG_CY = 0;
  localparam int FLAG_AC = 1;
  localparam int FLAG_S  = 2;
  localparam int FLAG_Z  = 3;
  localparam int FLAG_P  = 4;

  localparam logic [1:0] LEN_ONE   = 2'd1;
  localparam logic [1:0] LEN_TWO   = 2'd2;
  localparam logic [1:0] LEN_THREE = 2'd3;

endpackage

/* design/cpu80_if.sv */
// Valid/ready channel interfaces for the 8080 subset execute unit.
// Depends on cpu80_pkg for the beat structs.
interface cpu80_in_if;
  logic                valid;
  logic                ready;
  cpu80_pkg::in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface cpu80_out_if;
  logic                 valid;
  logic                 ready;
  cpu80_pkg::out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* design/cpu8080_subset_execute_unit.sv */
// Execute unit for a subset of the 8080: one instruction per input beat.
// Depends on cpu80_pkg and the channel interfaces in cpu80_if.sv.
//
// Usage:
//   in_ch carries one instruction per beat: the opcode byte and the two
//   bytes after it. out_ch returns exactly one beat per instruction with
//   the new program counter, an optional accumulator store (address and
//   value, zero when no store) and the accumulator and flags afterwards.
//   A beat is taken at a rising edge with valid and ready both high.
// Pipeline: an instruction passes through the input register, then the
//   result register, whose output is the result beat. Throughput: one
//   instruction per cycle while out_ch does not stall; the register file,
//   stack pointer, program counter and flags update in the cycle the
//   instruction moves from the input register to the result register, so
//   the next instruction sees them at once.
// Stall: when out_ch stalls, the result register holds and the input
//   register holds behind it; in_ch.ready drops only once both are full.
// Reset: rst_n (synchronous, active low) clears all registers, the program
//   counter and the flags, and empties both stages.
module cpu8080_subset_execute_unit (
  input  logic               clk,
  input  logic               rst_n,
  cpu80_in_if.sink           in_ch,
  cpu80_out_if.source        out_ch
);

  logic                 in_valid_r;
  cpu80_pkg::in_item_t  in_r;
  logic                 out_valid_r;
  cpu80_pkg::out_item_t out_r;

  logic [7:0]  b_r, c_r, d_r, e_r, h_r, l_r, a_r;
  logic [7:0]  b_nxt, c_nxt, d_nxt, e_nxt, h_nxt, l_nxt, a_nxt;
  logic [15:0] sp_r, sp_nxt;
  logic [15:0] pc_r, pc_nxt;
  logic [4:0]  flags_r, flags_nxt;

  logic advance;
  logic take_in;

  logic [7:0]  op;
  logic [2:0]  regcode;
  logic [2:0]  low3;
  logic [1:0]  pair;
  logic [7:0]  reg_val;
  logic [7:0]  reg_res;
  logic [15:0] pair_val;
  logic [15:0] pair_res;
  logic [1:0]  len;
  logic        strobe;
  logic        reg_wr;
  logic        pair_wr;
  cpu80_pkg::out_item_t out_nxt;

  assign advance   = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !in_valid_r || advance;
  assign take_in   = in_ch.valid && in_ch.ready;

  assign op      = in_r.mode;
  assign regcode = op[5:3];
  assign low3    = op[2:0];
  assign pair    = op[5:4];

  always_comb begin
    case (regcode)
      cpu80_pkg::REG_B: reg_val = b_r;
      cpu80_pkg::REG_C: reg_val = c_r;
      cpu80_pkg::REG_D: reg_val = d_r;
      cpu80_pkg::REG_E: reg_val = e_r;
      cpu80_pkg::REG_H: reg_val = h_r;
      cpu80_pkg::REG_L: reg_val = l_r;
      cpu80_pkg::REG_A: reg_val = a_r;
      default:          reg_val = 8'h00;
    endcase
  end

  always_comb begin
    case (pair)
      cpu80_pkg::PAIR_BC: pair_val = {b_r, c_r};
      cpu80_pkg::PAIR_DE: pair_val = {d_r, e_r};
      cpu80_pkg::PAIR_HL: pair_val = {h_r, l_r};
      default:            pair_val = sp_r;
    endcase
  end

  always_comb begin
    len       = cpu80_pkg::LEN_ONE;
    strobe    = 1'b0;
    reg_wr    = 1'b0;
    reg_res   = reg_val;
    pair_wr   = 1'b0;
    pair_res  = pair_val;
    flags_nxt = flags_r;
    if (op[7:6] == cpu80_pkg::GROUP_MISC) begin
      if (op[3:0] == cpu80_pkg::LOW_LXI) begin
        pair_wr  = 1'b1;
        pair_res = {in_r.imm_high, in_r.imm_low};
        len      = cpu80_pkg::LEN_THREE;
      end else if (op == cpu80_pkg::OP_STAX_B || op == cpu80_pkg::OP_STAX_D) begin
        strobe = 1'b1;
      end else if (op[3:0] == cpu80_pkg::LOW_INX) begin
        pair_wr  = 1'b1;
        pair_res = pair_val + 16'd1;
      end else if (low3 == cpu80_pkg::LOW3_INR || low3 == cpu80_pkg::LOW3_DCR) begin
        if (regcode != cpu80_pkg::REG_M) begin
          reg_wr = 1'b1;
          if (low3 == cpu80_pkg::LOW3_INR) begin
            reg_res = reg_val + 8'd1;
            flags_nxt[cpu80_pkg::FLAG_AC] = (reg_res[3:0] == 4'h0);
          end else begin
            reg_res = reg_val - 8'd1;
            flags_nxt[cpu80_pkg::FLAG_AC] = (reg_res[3:0] != 4'hf);
          end
          flags_nxt[cpu80_pkg::FLAG_S] = reg_res[7];
          flags_nxt[cpu80_pkg::FLAG_Z] = (reg_res == 8'h00);
          flags_nxt[cpu80_pkg::FLAG_P] = ~^reg_res;
        end
      end else if (low3 == cpu80_pkg::LOW3_MVI) begin
        if (regcode != cpu80_pkg::REG_M) begin
          reg_wr  = 1'b1;
          reg_res = in_r.imm_low;
          len     = cpu80_pkg::LEN_TWO;
        end
      end else if (op == cpu80_pkg::OP_CMC) begin
        flags_nxt[cpu80_pkg::FLAG_CY] = ~flags_r[cpu80_pkg::FLAG_CY];
      end
    end
  end

  always_comb begin
    b_nxt  = b_r;
    c_nxt  = c_r;
    d_nxt  = d_r;
    e_nxt  = e_r;
    h_nxt  = h_r;
    l_nxt  = l_r;
    a_nxt  = a_r;
    sp_nxt = sp_r;
    if (reg_wr) begin
      case (regcode)
        cpu80_pkg::REG_B: b_nxt = reg_res;
        cpu80_pkg::REG_C: c_nxt = reg_res;
        cpu80_pkg::REG_D: d_nxt = reg_res;
        cpu80_pkg::REG_E: e_nxt = reg_res;
        cpu80_pkg::REG_H: h_nxt = reg_res;
        cpu80_pkg::REG_L: l_nxt = reg_res;
        cpu80_pkg::REG_A: a_nxt = reg_res;
        default: ;
      endcase
    end
    if (pair_wr) begin
      case (pair)
        cpu80_pkg::PAIR_BC: {b_nxt, c_nxt} = pair_res;
        cpu80_pkg::PAIR_DE: {d_nxt, e_nxt} = pair_res;
        cpu80_pkg::PAIR_HL: {h_nxt, l_nxt} = pair_res;
        default:            sp_nxt = pair_res;
      endcase
    end
  end

  assign pc_nxt = pc_r + {14'd0, len};

  always_comb begin
    out_nxt.next_pc         = pc_nxt;
    out_nxt.write_strobe    = strobe;
    out_nxt.write_address   = strobe ? pair_val : 16'h0000;
    out_nxt.write_value     = strobe ? a_r : 8'h00;
    out_nxt.accumulator_out = a_nxt;
    out_nxt.flags_out       = flags_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      b_r     <= 8'h00;
      c_r     <= 8'h00;
      d_r     <= 8'h00;
      e_r     <= 8'h00;
      h_r     <= 8'h00;
      l_r     <= 8'h00;
      a_r     <= 8'h00;
      sp_r    <= 16'h0000;
      pc_r    <= 16'h0000;
      flags_r <= 5'h00;
    end else begin
      if (take_in) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= in_valid_r;
      end
      if (advance && in_valid_r) begin
        b_r     <= b_nxt;
        c_r     <= c_nxt;
        d_r     <= d_nxt;
        e_r     <= e_nxt;
        h_r     <= h_nxt;
        l_r     <= l_nxt;
        a_r     <= a_nxt;
        sp_r    <= sp_nxt;
        pc_r    <= pc_nxt;
        flags_r <= flags_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_in) begin
      in_r <= in_ch.payload;
    end
    if (advance && in_valid_r) begin
      out_r <= out_nxt;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.payload = out_r;

  a_no_store_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.write_strobe) |->
      (out_r.write_address == 16'h0000 && out_r.write_value == 8'h00))
    else $error("store fields nonzero without a store");

  a_store_keeps_acc: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.write_strobe) |-> (out_r.write_value == out_r.accumulator_out))
    else $error("store changed the accumulator");

  a_pc_step: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && in_valid_r) |=>
      ((16'(pc_r - $past(pc_r)) == 16'd1) || (16'(pc_r - $past(pc_r)) == 16'd2) ||
       (16'(pc_r - $past(pc_r)) == 16'd3)))
    else $error("program counter step out of range");

  a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !(advance && in_valid_r) |=> ($stable(pc_r) && $stable(a_r) && $stable(flags_r)))
    else $error("state changed without a retiring instruction");

  a_out_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && in_valid_r) |=>
      (out_r.next_pc == pc_r && out_r.accumulator_out == a_r && out_r.flags_out == flags_r))
    else $error("result beat disagrees with architectural state");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!in_valid_r && !out_valid_r))
    else $error("stages not empty after reset");

endmodule
